>>> sv/fysh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fysh_pkg
// shared types and constants of the fisher-yates shuffle engine
// ----------------------------------------------------------------------------
package fysh_pkg;

  // list storage
  localparam int DEPTH      = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;

  // fixed field widths
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int WORD_W = 64;

  // remainder unit: bits retired per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = WORD_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // command queue
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_FILL_W = $clog2(Q_DEPTH + 1);

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RAND = 1'b1;

  typedef enum logic [1:0] {
    PH_LOAD = 2'd0,
    PH_SHUF = 2'd1
  } ph_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SWAP = 1'b1
  } cmd_op_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_DIV   = 3'd1,
    BK_RDJ   = 3'd2,
    BK_WRI   = 3'd3,
    BK_WRJ   = 3'd4,
    BK_ERD   = 3'd5,
    BK_ECAP  = 3'd6,
    BK_EWAIT = 3'd7
  } bk_state_t;

  typedef struct packed {
    logic                 req_type;
    logic [VAL_W-1:0]     element_value;
    logic                 is_last;
    logic [WORD_W-1:0]    random_word;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0]     out_value;
    logic [POS_W-1:0]     out_position;
    logic                 out_last;
  } out_item_t;

  // one queued command: a load or a swap, optionally followed by emitting the list
  typedef struct packed {
    cmd_op_t              op;
    logic                 emit;
    logic [IDX_W-1:0]     idx;
    logic [CNT_W-1:0]     cnt;
    logic [WORD_W-1:0]    data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

endpackage

>>> sv/fisher_yates_shuffle_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisher_yates_shuffle_engine_top
// loads a list, shuffles it with supplied random words, emits it in order
// ----------------------------------------------------------------------------
//
//   channel  ports                         direction  carries
//   in       in_valid in_ready in_data     sink       load item or random word
//   out      out_valid out_ready out_data  source     one shuffled list entry
//
// a load item is taken whenever the command queue has room and is
// written to the element store in the cycle the back end pops it from the queue
// a random word takes the back end through queue pop, the remainder unit
// (8 bits of the word per cycle), then read j, write i, write j
// each result item goes through store read, capture and handshake, the last
// held as long as the output waits on out_ready
// reset clears phase, counters, queue and output valid; the element store is
// not cleared, only written entries are ever read
// a stalled output holds the back end only; the front keeps taking items
// until the two-entry queue fills
//
module fisher_yates_shuffle_engine_top import fysh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // front to queue
  logic    q_push;
  cmd_t    q_cmd;

  // queue to back
  logic    q_pop;
  cmd_t    q_head;
  q_stat_t q_stat;

  // front: phase tracking and classification, ignored items are just dropped
  fysh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // decoupling queue
  fysh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // back: element store, remainder unit, swap and readout sequencer
  fysh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/fysh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fysh_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module fysh_ram #(
  parameter int DATA_W  = 32,
  parameter int N_WORDS = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((N_WORDS > 1) ? $clog2(N_WORDS) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                           wdata,
  input  logic [((N_WORDS > 1) ? $clog2(N_WORDS) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                           rdata
);

  logic [DATA_W-1:0] mem_r [N_WORDS];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/fysh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fysh_front
// accepts items, tracks phase, count and swap index, queues commands
// ----------------------------------------------------------------------------
module fysh_front import fysh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output cmd_t     q_cmd
);

  ph_t              phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] swap_r, swap_nxt;

  logic             acc;
  logic             room;
  logic [CNT_W-1:0] cnt_after;
  logic             closes;
  logic             shuf_done;

  assign in_ready  = !q_stat.full;
  assign acc       = in_valid && in_ready;
  assign room      = count_r < CNT_W'(DEPTH);
  assign cnt_after = room ? count_r + 1'b1 : count_r;
  assign closes    = in_data.req_type == REQ_LOAD && in_data.is_last;
  assign shuf_done = swap_r <= IDX_W'(1);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      case (phase_r)
        PH_SHUF: begin
          if (in_data.req_type == REQ_RAND && shuf_done) begin
            phase_nxt = PH_LOAD;
          end
        end
        default: begin
          if (closes && cnt_after >= CNT_W'(2)) begin
            phase_nxt = PH_SHUF;
          end
        end
      endcase
    end
  end

  // commands and counters
  always_comb begin
    q_push      = 1'b0;
    q_cmd.op    = CMD_LOAD;
    q_cmd.emit  = 1'b0;
    q_cmd.idx   = IDX_W'(count_r);
    q_cmd.cnt   = cnt_after;
    q_cmd.data  = WORD_W'(in_data.element_value);
    count_nxt   = count_r;
    swap_nxt    = swap_r;
    if (acc) begin
      case (phase_r)
        PH_SHUF: begin
          if (in_data.req_type == REQ_RAND) begin
            q_push     = 1'b1;
            q_cmd.op   = CMD_SWAP;
            q_cmd.idx  = swap_r;
            q_cmd.cnt  = count_r;
            q_cmd.data = in_data.random_word;
            q_cmd.emit = shuf_done;
            if (shuf_done) begin
              count_nxt = '0;
              swap_nxt  = '0;
            end else begin
              swap_nxt = swap_r - 1'b1;
            end
          end
        end
        default: begin
          if (in_data.req_type == REQ_LOAD) begin
            q_push    = room;
            count_nxt = cnt_after;
            if (in_data.is_last) begin
              if (cnt_after < CNT_W'(2)) begin
                // single element list goes straight out
                q_cmd.emit = 1'b1;
                count_nxt  = '0;
              end else begin
                swap_nxt = IDX_W'(cnt_after - 1'b1);
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LOAD;
      count_r <= '0;
      swap_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      swap_r  <= swap_nxt;
    end
  end

endmodule

>>> sv/fysh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fysh_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module fysh_queue import fysh_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t                mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_FILL_W-1:0] fill_r, fill_nxt;
  logic                do_push, do_pop;

  assign stat.full     = fill_r == Q_FILL_W'(Q_DEPTH);
  assign stat.nonempty = fill_r != '0;
  assign head          = mem_r[rd_ptr_r];
  assign do_pop        = pop && stat.nonempty;
  assign do_push       = push && (!stat.full || do_pop);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

>>> sv/fysh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fysh_back
// executes queued commands: element writes, remainder and swap, list readout
// ----------------------------------------------------------------------------
module fysh_back import fysh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      q_head,
  input  q_stat_t   q_stat,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  bk_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]      i_r;
  logic [WORD_W-1:0]     word_r;
  logic [IDX_W-1:0]      rem_r;
  logic [STEP_W-1:0]     step_r;
  logic [ELEM_WIDTH-1:0] tmp_r;
  logic                  emit_r;
  logic [CNT_W-1:0]      n_r;
  logic [IDX_W-1:0]      k_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  // control from the state decode
  logic                  start;
  logic                  div_run;
  logic                  out_load;
  logic                  out_take;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_rdata;

  // remainder step
  logic [CNT_W-1:0]      divisor;
  logic [IDX_W-1:0]      rem_v;
  logic [CNT_W-1:0]      sh_v;
  logic                  step_last;
  logic                  k_last;

  assign divisor   = {1'b0, i_r} + 1'b1;
  assign step_last = step_r == STEP_W'(DIV_STEPS - 1);
  assign k_last    = ({1'b0, k_r} + 1'b1) == n_r;

  // restoring remainder, DIV_BITS bits of the word per cycle
  always_comb begin
    rem_v = rem_r;
    sh_v  = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      sh_v = {rem_v, word_r[WORD_W-1-b]};
      if (sh_v >= divisor) begin
        sh_v = sh_v - divisor;
      end
      rem_v = sh_v[IDX_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_stat.nonempty) begin
          if (q_head.op == CMD_SWAP) begin
            state_nxt = BK_DIV;
          end else if (q_head.emit) begin
            state_nxt = BK_ERD;
          end
        end
      end
      BK_DIV:   if (step_last) state_nxt = BK_RDJ;
      BK_RDJ:   state_nxt = BK_WRI;
      BK_WRI:   state_nxt = BK_WRJ;
      BK_WRJ:   state_nxt = emit_r ? BK_ERD : BK_IDLE;
      BK_ERD:   state_nxt = BK_ECAP;
      BK_ECAP:  state_nxt = BK_EWAIT;
      BK_EWAIT: begin
        if (out_ready) begin
          state_nxt = out_data_r.out_last ? BK_IDLE : BK_ERD;
        end
      end
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the state decode
  always_comb begin
    q_pop     = 1'b0;
    start     = 1'b0;
    div_run   = 1'b0;
    out_load  = 1'b0;
    out_take  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = q_head.idx;
    ram_wdata = ELEM_WIDTH'(q_head.data);
    ram_raddr = i_r;
    case (state_r)
      BK_IDLE: begin
        if (q_stat.nonempty) begin
          q_pop  = 1'b1;
          start  = 1'b1;
          ram_we = q_head.op == CMD_LOAD;
        end
      end
      BK_DIV: begin
        div_run = 1'b1;
      end
      BK_RDJ: begin
        ram_raddr = rem_r;
      end
      BK_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = ram_rdata;
      end
      BK_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = rem_r;
        ram_wdata = tmp_r;
      end
      BK_ERD: begin
        ram_raddr = k_r;
      end
      BK_ECAP: begin
        out_load = 1'b1;
      end
      BK_EWAIT: begin
        out_take = out_ready;
      end
      default: begin
      end
    endcase
  end

  fysh_ram #(
    .DATA_W  (ELEM_WIDTH),
    .N_WORDS (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      i_r    <= q_head.idx;
      word_r <= q_head.data;
      rem_r  <= '0;
      step_r <= '0;
      emit_r <= q_head.emit;
      n_r    <= q_head.cnt;
      k_r    <= '0;
    end
    if (div_run) begin
      word_r <= word_r << DIV_BITS;
      rem_r  <= rem_v;
      step_r <= step_r + 1'b1;
      // entry i is read throughout the remainder pass
      tmp_r  <= ram_rdata;
    end
    if (out_load) begin
      out_data_r.out_value    <= VAL_W'(ram_rdata);
      out_data_r.out_position <= POS_W'(k_r);
      out_data_r.out_last     <= k_last;
    end
    if (out_take) begin
      k_r <= k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/fysh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fysh_checker
// port-level checks of the shuffle engine, bound to the top level
// ----------------------------------------------------------------------------
module fysh_checker import fysh_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // after reset no result and the input is ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // a taken result drops valid straight after the handshake
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result valid straight after handshake");

  // next entry of the list follows, after store read and capture, at the next position
  a_next_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.out_last |-> ##3
      (out_valid && out_data.out_position == $past(out_data.out_position, 3) + 1'b1))
    else $error("list readout out of sequence");

endmodule

bind fisher_yates_shuffle_engine_top fysh_checker u_checker (.*);
